// ----- rtl/core/cpu8alu_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpu8alu_pkg
// Shared types and constants for the 8-bit register/ALU execute core.
// ---------------------------------------------------------------------------
package cpu8alu_pkg;

  // Operation codes carried in the action field
  typedef enum logic [4:0] {
    ACT_ADC   = 5'd0,
    ACT_AND   = 5'd1,
    ACT_ORA   = 5'd2,
    ACT_EOR   = 5'd3,
    ACT_CMP   = 5'd4,
    ACT_CPX   = 5'd5,
    ACT_CPY   = 5'd6,
    ACT_BIT   = 5'd7,
    ACT_ASL_A = 5'd8,
    ACT_ASL_M = 5'd9,
    ACT_LSR_A = 5'd10,
    ACT_LSR_M = 5'd11,
    ACT_INC   = 5'd12,
    ACT_DEC   = 5'd13,
    ACT_INX   = 5'd14,
    ACT_INY   = 5'd15,
    ACT_DEX   = 5'd16,
    ACT_DEY   = 5'd17,
    ACT_LDA   = 5'd18,
    ACT_LDX   = 5'd19,
    ACT_LDY   = 5'd20,
    ACT_CLC   = 5'd21,
    ACT_CLD   = 5'd22,
    ACT_CLI   = 5'd23,
    ACT_CLV   = 5'd24,
    ACT_PHA   = 5'd25,
    ACT_PHP   = 5'd26
  } action_t;

  // Status bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_B = 4;
  localparam int FLAG_U = 5;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  // Stack lives in page one
  localparam logic [7:0] STACK_PAGE = 8'h01;

  // One input beat
  typedef struct packed {
    logic [4:0] action;
    logic [7:0] operand;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  flags_out;
    logic        mem_write;
    logic        mem_is_stack;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
  } result_t;

  // Architectural registers
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
    logic [7:0] sp;
  } arch_t;

endpackage

// ----- rtl/core/cpu8alu_exec.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpu8alu_exec
// Single-pass execute logic: one operation against the current registers,
// giving the next register values and the memory write of the operation.
// ---------------------------------------------------------------------------
module cpu8alu_exec
  import cpu8alu_pkg::*;
(
  input  item_t   item,
  input  arch_t   arch,
  output arch_t   arch_next,
  output result_t result
);

  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] cmp_reg;
  logic [7:0] val;
  logic       set_zn;
  logic       wr;
  logic       stk;
  logic [7:0] data;
  logic [7:0] m;

  assign m = item.operand;

  // Pick the register that a compare works on
  always_comb begin
    case (item.action)
      ACT_CPX: cmp_reg = arch.x;
      ACT_CPY: cmp_reg = arch.y;
      default: cmp_reg = arch.a;
    endcase
  end

  // Adder for ADC; subtractor shared by the compares
  assign sum  = {1'b0, arch.a} + {1'b0, m} + {8'd0, arch.p[FLAG_C]};
  assign diff = {1'b0, cmp_reg} - {1'b0, m};

  // Decode the operation
  always_comb begin
    arch_next = arch;
    val       = 8'd0;
    set_zn    = 1'b0;
    wr        = 1'b0;
    stk       = 1'b0;
    data      = 8'd0;
    case (item.action)
      ACT_ADC: begin
        val                 = sum[7:0];
        set_zn              = 1'b1;
        arch_next.a         = sum[7:0];
        arch_next.p[FLAG_C] = sum[8];
        arch_next.p[FLAG_V] = ~(arch.a[7] ^ m[7]) & (arch.a[7] ^ sum[7]);
      end
      ACT_AND: begin
        val         = arch.a & m;
        set_zn      = 1'b1;
        arch_next.a = arch.a & m;
      end
      ACT_ORA: begin
        val         = arch.a | m;
        set_zn      = 1'b1;
        arch_next.a = arch.a | m;
      end
      ACT_EOR: begin
        val         = arch.a ^ m;
        set_zn      = 1'b1;
        arch_next.a = arch.a ^ m;
      end
      ACT_CMP, ACT_CPX, ACT_CPY: begin
        val                 = diff[7:0];
        set_zn              = 1'b1;
        arch_next.p[FLAG_C] = ~diff[8];
      end
      ACT_BIT: begin
        arch_next.p[FLAG_Z] = ((arch.a & m) == 8'd0);
        arch_next.p[FLAG_N] = m[7];
        arch_next.p[FLAG_V] = m[6];
      end
      ACT_ASL_A: begin
        val                 = {arch.a[6:0], 1'b0};
        set_zn              = 1'b1;
        arch_next.a         = {arch.a[6:0], 1'b0};
        arch_next.p[FLAG_C] = arch.a[7];
      end
      ACT_ASL_M: begin
        val                 = {m[6:0], 1'b0};
        set_zn              = 1'b1;
        arch_next.p[FLAG_C] = m[7];
        wr                  = 1'b1;
        data                = {m[6:0], 1'b0};
      end
      ACT_LSR_A: begin
        val                 = {1'b0, arch.a[7:1]};
        set_zn              = 1'b1;
        arch_next.a         = {1'b0, arch.a[7:1]};
        arch_next.p[FLAG_C] = arch.a[0];
      end
      ACT_LSR_M: begin
        val                 = {1'b0, m[7:1]};
        set_zn              = 1'b1;
        arch_next.p[FLAG_C] = m[0];
        wr                  = 1'b1;
        data                = {1'b0, m[7:1]};
      end
      ACT_INC: begin
        val    = m + 8'd1;
        set_zn = 1'b1;
        wr     = 1'b1;
        data   = m + 8'd1;
      end
      ACT_DEC: begin
        val    = m - 8'd1;
        set_zn = 1'b1;
        wr     = 1'b1;
        data   = m - 8'd1;
      end
      ACT_INX: begin
        val         = arch.x + 8'd1;
        set_zn      = 1'b1;
        arch_next.x = arch.x + 8'd1;
      end
      ACT_INY: begin
        val         = arch.y + 8'd1;
        set_zn      = 1'b1;
        arch_next.y = arch.y + 8'd1;
      end
      ACT_DEX: begin
        val         = arch.x - 8'd1;
        set_zn      = 1'b1;
        arch_next.x = arch.x - 8'd1;
      end
      ACT_DEY: begin
        val         = arch.y - 8'd1;
        set_zn      = 1'b1;
        arch_next.y = arch.y - 8'd1;
      end
      ACT_LDA: begin
        val         = m;
        set_zn      = 1'b1;
        arch_next.a = m;
      end
      ACT_LDX: begin
        val         = m;
        set_zn      = 1'b1;
        arch_next.x = m;
      end
      ACT_LDY: begin
        val         = m;
        set_zn      = 1'b1;
        arch_next.y = m;
      end
      ACT_CLC: arch_next.p[FLAG_C] = 1'b0;
      ACT_CLD: arch_next.p[FLAG_D] = 1'b0;
      ACT_CLI: arch_next.p[FLAG_I] = 1'b0;
      ACT_CLV: arch_next.p[FLAG_V] = 1'b0;
      ACT_PHA: begin
        wr           = 1'b1;
        stk          = 1'b1;
        data         = arch.a;
        arch_next.sp = arch.sp - 8'd1;
      end
      ACT_PHP: begin
        wr           = 1'b1;
        stk          = 1'b1;
        data         = arch.p;
        data[FLAG_B] = 1'b1;
        data[FLAG_U] = 1'b1;
        arch_next.sp = arch.sp - 8'd1;
      end
      default: ;
    endcase

    // Zero and negative follow the result value
    if (set_zn) begin
      arch_next.p[FLAG_Z] = (val == 8'd0);
      arch_next.p[FLAG_N] = val[7];
    end
  end

  // Assemble the result beat from the updated registers
  always_comb begin
    result.acc_out      = arch_next.a;
    result.x_out        = arch_next.x;
    result.y_out        = arch_next.y;
    result.flags_out    = arch_next.p;
    result.mem_write    = wr;
    result.mem_is_stack = stk;
    result.mem_address  = stk ? {STACK_PAGE, arch.sp} : 16'd0;
    result.mem_data     = data;
  end

endmodule

// ----- rtl/core/cpu8alu_state.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpu8alu_state
// Architectural register file: A, X, Y, status and stack pointer,
// loaded as one group when an operation retires.
// ---------------------------------------------------------------------------
module cpu8alu_state
  import cpu8alu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  arch_t arch_next,
  output arch_t arch
);

  // Clear on reset, load on retire
  always_ff @(posedge clk) begin
    if (rst) begin
      arch <= '0;
    end else if (load) begin
      arch <= arch_next;
    end
  end

endmodule

// ----- rtl/core/cpu8_register_alu_execute_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpu8_register_alu_execute_core
// Execute stage of an 8-bit accumulator CPU: ALU, index registers, status
// flags and stack pointer, with push writes to page one.
//
//   channel  direction  handshake              payload
//   item     in         item_valid/item_stall  item_t   (action, operand)
//   result   out        result_valid/result_stall  result_t
//
// Each operation goes from the input register through the execute logic
// to the result register; one operation retires per cycle unless stalled.
// The input register feeds the execute logic; the register file updates
// at the same edge the result register loads, so back-to-back operations
// see each other's results. Reset clears the register file and valid bits.
// A stalled result holds the pipe; the input register still fills once.
// ---------------------------------------------------------------------------
module cpu8_register_alu_execute_core
  import cpu8alu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic    stage_valid;
  item_t   stage_item;
  logic    advance;
  arch_t   arch;
  arch_t   arch_next;
  result_t exec_result;

  // Execute stage moves when the result register is free or draining
  assign advance    = stage_valid & (~result_valid | ~result_stall);
  assign item_stall = stage_valid & ~advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (~item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (~item_stall && item_valid) begin
      stage_item <= item;
    end
  end

  cpu8alu_exec u_exec (
    .item      (stage_item),
    .arch      (arch),
    .arch_next (arch_next),
    .result    (exec_result)
  );

  cpu8alu_state u_state (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .arch_next (arch_next),
    .arch      (arch)
  );

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (~result_valid | ~result_stall) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= exec_result;
    end
  end

endmodule
